### sv/mpra_pkg.sv
package mpra_pkg;

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_BLOCK   = 2'd2;
  localparam logic [1:0] REQ_UNBLOCK = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SPACE  = 3'd1;
  localparam logic [2:0] ST_RANGE     = 3'd2;
  localparam logic [2:0] ST_OCCUPIED  = 3'd3;
  localparam logic [2:0] ST_NOT_START = 3'd4;
  localparam logic [2:0] ST_PAGE_FREE = 3'd5;

  localparam logic [1:0] CFG_BASE   = 2'd0;
  localparam logic [1:0] CFG_SHIFT  = 2'd1;
  localparam logic [1:0] CFG_USABLE = 2'd2;

  localparam logic [1:0] MARK_FREE  = 2'd0;
  localparam logic [1:0] MARK_FIRST = 2'd1;
  localparam logic [1:0] MARK_BLOCK = 2'd3;

  typedef logic [47:0] addr_t;
  typedef logic [12:0] cnt_t;

endpackage

### sv/marked_page_run_allocator.sv
// Page allocator over a store of 2-bit marks, one per page, held in a simple
// dual-port RAM (one write, one registered read per cycle). A request word is taken
// when the block is idle; the result word appears after a walk over the mark
// store in which each page visit takes a read state and a check state, because
// of the registered read. After reset a clearing pass writes every page free,
// during which no request is taken. Allocate walks from page 0 to the end of the
// first free run of the requested length, then backward and, if page 0 is reached
// free, forward for a neighbour mark, then writes the run at one page per cycle.
// Free checks the page before the run; free and unblock then clear the run's
// marks. Block checks its range and then writes it. Configuration writes are
// taken at any time but are meant only while the block is idle.
module marked_page_run_allocator
  import mpra_pkg::*;
#(
  parameter int PAGES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [12:0] page_count,
  input  logic [47:0] free_address,
  input  logic [11:0] start_page,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [47:0] result_address,
  output logic [12:0] pages_done
);

  localparam int AW = $clog2(PAGES);
  // Wide enough for page numbers and for the 13-bit request counts.
  localparam int PW = (AW + 1 > 13) ? AW + 1 : 13;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_RD     = 4'd3;
  localparam logic [3:0] S_CHK    = 4'd4;
  localparam logic [3:0] S_WRITE  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  // Walk phases reuse the read/check pair.
  localparam logic [2:0] W_SCAN  = 3'd0;
  localparam logic [2:0] W_BACK  = 3'd1;
  localparam logic [2:0] W_FWD   = 3'd2;
  localparam logic [2:0] W_BCHK  = 3'd3;
  localparam logic [2:0] W_CLR   = 3'd4;
  localparam logic [2:0] W_PREV  = 3'd5;

  logic [3:0]  state;
  logic [2:0]  phase;
  addr_t       base;
  logic [4:0]  shift;
  logic [12:0] usable;
  logic [PW-1:0] lim;
  logic [PW:0]   used;

  logic [1:0]  rtype;
  logic [PW-1:0] n;
  addr_t       faddr;
  logic [PW-1:0] sp;

  logic [PW-1:0] p;
  logic [PW-1:0] streak;
  logic [PW-1:0] start;
  logic [PW-1:0] cnt;
  logic [1:0]  cur;
  logic [1:0]  wmark;

  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [1:0]  wdata, rdata;

  mpra_ram #(.WIDTH(2), .DEPTH(PAGES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  addr_t  off;
  addr_t  pg;
  logic [PW:0] sum_used;
  logic [PW:0] sp_end;

  always_comb begin
    off      = faddr - base;
    pg       = off >> shift;
    sum_used = used + {1'b0, n};
    sp_end   = {1'b0, sp} + {1'b0, n};
    lim = (PW'(usable) < PW'(PAGES)) ? PW'(usable) : PW'(PAGES);
  end

  assign in_stall = (state != S_IDLE);
  assign raddr = p[AW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = p[AW-1:0];
    wdata = wmark;
    if (state == S_CLEAR) begin
      we = 1'b1;
      wdata = MARK_FREE;
    end else if (state == S_WRITE) begin
      we = 1'b1;
    end else if (state == S_CHK && phase == W_CLR && rdata == cur && p < lim) begin
      we = 1'b1;
      wdata = MARK_FREE;
    end
  end

  function automatic logic [1:0] succ(input logic [1:0] m);
    succ = (m == MARK_FREE || m == MARK_BLOCK) ? MARK_FIRST : m + 2'd1;
  endfunction

  task automatic finish(input logic [2:0] st, input addr_t a, input logic [12:0] d);
    status         <= st;
    result_address <= a;
    pages_done     <= d;
    out_valid      <= 1'b1;
    state          <= S_DONE;
  endtask

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      p         <= '0;
      used      <= '0;
      out_valid <= 1'b0;
      base      <= '0;
      shift     <= 5'd12;
      usable    <= 13'd4096;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE:   base   <= cfg_data;
          CFG_SHIFT:  shift  <= cfg_data[4:0];
          CFG_USABLE: usable <= cfg_data[12:0];
          default: ;
        endcase
      end
      unique case (state)
        S_CLEAR: begin
          if (p == PW'(PAGES - 1)) begin
            state <= S_IDLE;
          end
          p <= p + 1'b1;
        end
        S_IDLE: begin
          if (in_valid) begin
            rtype <= req_type;
            n     <= PW'(page_count);
            faddr <= free_address;
            sp    <= PW'(start_page);
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (rtype)
            REQ_ALLOC: begin
              if (n == '0) finish(ST_RANGE, '0, '0);
              else if (sum_used >= {1'b0, lim}) finish(ST_NO_SPACE, '0, '0);
              else begin
                p <= '0; streak <= '0; phase <= W_SCAN; state <= S_RD;
              end
            end
            REQ_FREE: begin
              if (faddr < base || pg >= 48'(lim)) finish(ST_RANGE, '0, '0);
              else begin
                p <= PW'(pg); phase <= W_PREV; cur <= MARK_FREE; state <= S_RD;
              end
            end
            REQ_BLOCK: begin
              if (sp_end > {1'b0, lim}) finish(ST_RANGE, '0, '0);
              else if (n == '0) finish(ST_OK, '0, '0);
              else begin
                p <= sp; phase <= W_BCHK; state <= S_RD;
              end
            end
            default: begin
              if (sp >= lim) finish(ST_RANGE, '0, '0);
              else begin
                p <= sp; phase <= W_PREV; cur <= MARK_FREE; state <= S_RD;
              end
            end
          endcase
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          unique case (phase)
            W_SCAN: begin
              if (p >= lim) finish(ST_NO_SPACE, '0, '0);
              else begin
                state <= S_RD;
                if (rdata == MARK_FREE) begin
                  if (streak + 1'b1 >= n) begin
                    start <= p + 1'b1 - n;
                    if (p + 1'b1 == n) begin
                      p <= p + 1'b1; phase <= W_FWD;
                    end else begin
                      p <= p - n; phase <= W_BACK;
                    end
                  end else begin
                    streak <= streak + 1'b1; p <= p + 1'b1;
                  end
                end else begin
                  streak <= '0; p <= p + 1'b1;
                end
              end
            end
            W_BACK: begin
              if (rdata != MARK_FREE) begin
                wmark <= succ(rdata); p <= start; cnt <= '0;
                state <= S_WRITE;
              end else if (p == '0) begin
                p <= start + n; phase <= W_FWD; state <= S_RD;
              end else begin
                p <= p - 1'b1; state <= S_RD;
              end
            end
            W_FWD: begin
              if (p >= lim || rdata != MARK_FREE) begin
                wmark <= (p >= lim) ? MARK_FIRST : succ(rdata);
                p <= start; cnt <= '0; state <= S_WRITE;
              end else begin
                p <= p + 1'b1; state <= S_RD;
              end
            end
            W_BCHK: begin
              if (rdata != MARK_FREE) finish(ST_OCCUPIED, '0, '0);
              else if (p + 1'b1 == sp_end[PW-1:0]) begin
                p <= sp; wmark <= MARK_BLOCK; cnt <= '0; state <= S_WRITE;
              end else begin
                p <= p + 1'b1; state <= S_RD;
              end
            end
            W_PREV: begin
              // First visit reads the start page; for a free not at page 0, the second reads the page before it.
              if (cur == MARK_FREE) begin
                if (rdata == MARK_FREE) finish(ST_PAGE_FREE, '0, '0);
                else if (rtype == REQ_FREE && rdata == MARK_BLOCK)
                  finish(ST_OCCUPIED, '0, '0);
                else if (rtype == REQ_FREE && p != '0) begin
                  cur <= rdata; p <= p - 1'b1; state <= S_RD;
                end else begin
                  cur <= rdata; cnt <= '0; phase <= W_CLR; state <= S_RD;
                end
              end else if (rdata == cur) begin
                finish(ST_NOT_START, '0, '0);
              end else begin
                p <= p + 1'b1; cnt <= '0; phase <= W_CLR; state <= S_RD;
              end
            end
            default: begin
              if (p >= lim || rdata != cur) begin
                used <= (PW+1)'(({1'b0, cnt} >= used) ? '0 : used - {1'b0, cnt});
                finish(ST_OK, '0, 13'(cnt));
              end else if (rtype == REQ_UNBLOCK && n != '0 && cnt + 1'b1 >= n) begin
                used <= (PW+1)'(({1'b0, cnt} + 1'b1 >= used) ? '0
                                  : used - {1'b0, cnt} - 1'b1);
                finish(ST_OK, '0, 13'(cnt + 1'b1));
              end else begin
                cnt <= cnt + 1'b1; p <= p + 1'b1; state <= S_RD;
              end
            end
          endcase
        end
        S_WRITE: begin
          if (cnt + 1'b1 == n) begin
            if (rtype == REQ_ALLOC) begin
              used <= (PW+1)'(sum_used[12:0]);
              finish(ST_OK, base + (48'(start) << shift), 13'(n));
            end else begin
              finish(ST_OK, '0, 13'(n));
            end
          end else begin
            cnt <= cnt + 1'b1; p <= p + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/mpra_ram.sv
module mpra_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
